[src/sbt_pkg.sv]
// ---------------------------------------------------------------------------
// sbt_pkg: shared constants and functions for the source byte tokenizer
// Token kind codes, lexer mode codes and the byte classification
// functions used by the front end.
// ---------------------------------------------------------------------------
package sbt_pkg;

  localparam int OffsetWidthDefault = 24;
  localparam int LineWidthDefault   = 16;
  localparam int KindWidth          = 5;

  // lexer modes
  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_OP     = 3'd2;
  localparam logic [2:0] M_SLASH  = 3'd3;
  localparam logic [2:0] M_LINE   = 3'd4;
  localparam logic [2:0] M_BLOCK  = 3'd5;
  localparam logic [2:0] M_STAR   = 3'd6;
  localparam logic [2:0] M_STRING = 3'd7;

  // token kinds
  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_ERROR  = 5'd1;
  localparam logic [4:0] K_IDENT  = 5'd2;
  localparam logic [4:0] K_STRING = 5'd3;
  localparam logic [4:0] K_IF     = 5'd4;
  localparam logic [4:0] K_RET    = 5'd5;
  localparam logic [4:0] K_ELSE   = 5'd6;
  localparam logic [4:0] K_FUNC   = 5'd7;
  localparam logic [4:0] K_NONE   = 5'd0;
  localparam logic [4:0] K_SLASH  = 5'd31;

  // one-byte punctuation kind, K_NONE if not punctuation
  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    k = K_NONE;
    unique case (b)
      8'h28: k = 5'd8;
      8'h29: k = 5'd9;
      8'h7B: k = 5'd10;
      8'h7D: k = 5'd11;
      8'h5B: k = 5'd12;
      8'h5D: k = 5'd13;
      8'h2C: k = 5'd14;
      8'h2E: k = 5'd15;
      8'h3B: k = 5'd20;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // lone operator kind; its two-byte form is kind + 1
  function automatic logic [4:0] op_kind(input logic [7:0] b);
    logic [4:0] k;
    k = K_NONE;
    unique case (b)
      8'h2D: k = 5'd16;
      8'h2B: k = 5'd18;
      8'h2A: k = 5'd21;
      8'h21: k = 5'd23;
      8'h3D: k = 5'd25;
      8'h3C: k = 5'd27;
      8'h3E: k = 5'd29;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(input logic [7:0] b);
    logic [7:0] s;
    if (b == 8'h2D || b == 8'h2B || b == 8'h2A) begin
      s = b;
    end else begin
      s = 8'h3D;
    end
    return s;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return (l >= 8'h61 && l <= 8'h7A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

[src/sbt_front.sv]
// ---------------------------------------------------------------------------
// sbt_front: byte classifier and lexer state machine
// Takes one byte per cycle while take is high, tracks position and writes up
// to two tokens per byte into the token queue.
// ---------------------------------------------------------------------------
module sbt_front import sbt_pkg::*; #(
  parameter int OFFSET_WIDTH = OffsetWidthDefault,
  parameter int LINE_WIDTH   = LineWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              char_byte,
  output logic [1:0]              tok_count,
  output logic [KindWidth-1:0]    kind0,
  output logic [KindWidth-1:0]    kind1,
  output logic [LINE_WIDTH-1:0]   line0,
  output logic [LINE_WIDTH-1:0]   line1,
  output logic [LINE_WIDTH-1:0]   col0,
  output logic [LINE_WIDTH-1:0]   col1,
  output logic [OFFSET_WIDTH-1:0] soff0,
  output logic [OFFSET_WIDTH-1:0] soff1,
  output logic [OFFSET_WIDTH-1:0] eoff0,
  output logic [OFFSET_WIDTH-1:0] eoff1
);

  localparam logic [LINE_WIDTH-1:0]   LineMax = '1;
  localparam logic [OFFSET_WIDTH-1:0] OffMax  = '1;
  localparam logic [LINE_WIDTH-1:0]   LineOne = LINE_WIDTH'(1);

  logic [2:0]              mode, mode_next;
  logic [7:0]              pend, pend_next;
  logic [LINE_WIDTH-1:0]   tline, tline_next, tcol, tcol_next;
  logic [OFFSET_WIDTH-1:0] toff, toff_next;
  logic [LINE_WIDTH-1:0]   cline, cline_next, ccol, ccol_next;
  logic [OFFSET_WIDTH-1:0] coff, coff_next;
  logic [31:0]             prefix, prefix_next;
  logic [2:0]              ilen, ilen_next;

  // position after the current byte
  logic                    nl_any, nl_lf;
  logic [LINE_WIDTH-1:0]   adv_line_a, adv_line_l, adv_col_a, adv_col_l;
  logic [OFFSET_WIDTH-1:0] adv_off;
  logic [LINE_WIDTH-1:0]   line_inc, col_inc;
  logic [4:0]              ident_k;

  always_comb begin
    nl_lf      = char_byte == 8'h0A;
    nl_any     = nl_lf || char_byte == 8'h0D;
    adv_off    = (coff < OffMax) ? coff + OFFSET_WIDTH'(1) : coff;
    line_inc   = (cline < LineMax) ? cline + LineOne : cline;
    col_inc    = (ccol < LineMax) ? ccol + LineOne : ccol;
    adv_line_a = nl_any ? line_inc : cline;
    adv_col_a  = nl_any ? '0 : col_inc;
    adv_line_l = nl_lf ? line_inc : cline;
    adv_col_l  = nl_lf ? '0 : col_inc;
  end

  always_comb begin
    priority if (ilen == 3'd2 && prefix == 32'h0000_6966) begin
      ident_k = K_IF;
    end else if (ilen == 3'd3 && prefix == 32'h0072_6574) begin
      ident_k = K_RET;
    end else if (ilen == 3'd4 && prefix == 32'h656C_7365) begin
      ident_k = K_ELSE;
    end else if (ilen == 3'd4 && prefix == 32'h6675_6E63) begin
      ident_k = K_FUNC;
    end else begin
      ident_k = K_IDENT;
    end
  end

  // lexer next state and token generation
  always_comb begin
    logic fall;  // byte goes on to the idle handling
    logic [LINE_WIDTH-1:0]   fl, fc;
    logic [OFFSET_WIDTH-1:0] fo;
    mode_next = mode; pend_next = pend;
    tline_next = tline; tcol_next = tcol; toff_next = toff;
    cline_next = cline; ccol_next = ccol; coff_next = coff;
    prefix_next = prefix; ilen_next = ilen;
    tok_count = 2'd0;
    kind0 = K_NONE; kind1 = K_NONE;
    line0 = tline; col0 = tcol; soff0 = toff; eoff0 = coff;
    line1 = tline; col1 = tcol; soff1 = toff; eoff1 = coff;
    fall = 1'b0;
    fl = '0; fc = '0; fo = '0;

    unique case (mode)
      M_IDENT: begin
        if (is_letter(char_byte) || is_digit(char_byte)) begin
          if (ilen < 3'd4) prefix_next = {prefix[23:0], char_byte};
          if (ilen < 3'd7) ilen_next = ilen + 3'd1;
          cline_next = adv_line_a; ccol_next = adv_col_a; coff_next = adv_off;
        end else begin
          tok_count = 2'd1; kind0 = ident_k; fall = 1'b1;
        end
      end
      M_OP: begin
        if (char_byte == op_second(pend)) begin
          cline_next = adv_line_a; ccol_next = adv_col_a; coff_next = adv_off;
          tok_count = 2'd1; kind0 = op_kind(pend) + 5'd1; eoff0 = adv_off;
          mode_next = M_IDLE;
        end else begin
          tok_count = 2'd1; kind0 = op_kind(pend); fall = 1'b1;
        end
      end
      M_SLASH: begin
        if (char_byte == 8'h2F || char_byte == 8'h2A) begin
          cline_next = adv_line_a; ccol_next = adv_col_a; coff_next = adv_off;
          mode_next = (char_byte == 8'h2F) ? M_LINE : M_BLOCK;
        end else begin
          tok_count = 2'd1; kind0 = K_SLASH; fall = 1'b1;
        end
      end
      M_LINE: begin
        if (char_byte == 8'h0A || char_byte == 8'h00) begin
          fall = 1'b1;
        end else begin
          cline_next = adv_line_l; ccol_next = adv_col_l; coff_next = adv_off;
        end
      end
      M_BLOCK, M_STAR, M_STRING: begin
        if (char_byte == 8'h00) begin
          tok_count = 2'd1; kind0 = K_ERROR; fall = 1'b1;
        end else begin
          cline_next = adv_line_l; ccol_next = adv_col_l; coff_next = adv_off;
          if (mode == M_STRING) begin
            if (char_byte == 8'h22) begin
              tok_count = 2'd1; kind0 = K_STRING; eoff0 = adv_off;
              mode_next = M_IDLE;
            end
          end else if (mode == M_STAR && char_byte == 8'h2F) begin
            mode_next = M_IDLE;
          end else begin
            mode_next = (char_byte == 8'h2A) ? M_STAR : M_BLOCK;
          end
        end
      end
      default: fall = 1'b1;
    endcase

    if (fall) begin
      mode_next = M_IDLE;
      if (char_byte == 8'h00) begin
        // end of text: EOF at current position, then back to reset state
        fl = cline; fc = ccol; fo = coff;
        if (tok_count == 2'd0) begin
          kind0 = K_EOF; line0 = fl; col0 = fc; soff0 = fo; eoff0 = fo;
        end else begin
          kind1 = K_EOF; line1 = fl; col1 = fc; soff1 = fo; eoff1 = fo;
        end
        tok_count = tok_count + 2'd1;
        pend_next = '0; tline_next = LineOne; tcol_next = '0; toff_next = '0;
        cline_next = LineOne; ccol_next = '0; coff_next = '0;
        prefix_next = '0; ilen_next = '0;
      end else if (char_byte == 8'h20 || char_byte == 8'h09 || nl_any) begin
        cline_next = adv_line_a; ccol_next = adv_col_a; coff_next = adv_off;
      end else begin
        tline_next = cline; tcol_next = ccol; toff_next = coff;
        cline_next = adv_line_a; ccol_next = adv_col_a; coff_next = adv_off;
        if (is_letter(char_byte)) begin
          mode_next = M_IDENT; prefix_next = {24'd0, char_byte}; ilen_next = 3'd1;
        end else if (single_kind(char_byte) != K_NONE || !(op_kind(char_byte) != K_NONE
                     || char_byte == 8'h2F || char_byte == 8'h22)) begin
          fc = ccol;
          if (tok_count == 2'd0) begin
            kind0 = (single_kind(char_byte) != K_NONE) ? single_kind(char_byte) : K_ERROR;
            line0 = cline; col0 = fc; soff0 = coff; eoff0 = adv_off;
          end else begin
            kind1 = (single_kind(char_byte) != K_NONE) ? single_kind(char_byte) : K_ERROR;
            line1 = cline; col1 = fc; soff1 = coff; eoff1 = adv_off;
          end
          tok_count = tok_count + 2'd1;
        end else if (op_kind(char_byte) != K_NONE) begin
          mode_next = M_OP; pend_next = char_byte;
        end else if (char_byte == 8'h2F) begin
          mode_next = M_SLASH;
        end else begin
          mode_next = M_STRING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= '0;
      tline <= LineOne; tcol <= '0; toff <= '0;
      cline <= LineOne; ccol <= '0; coff <= '0;
      prefix <= '0; ilen <= '0;
    end else if (take) begin
      mode <= mode_next; pend <= pend_next;
      tline <= tline_next; tcol <= tcol_next; toff <= toff_next;
      cline <= cline_next; ccol <= ccol_next; coff <= coff_next;
      prefix <= prefix_next; ilen <= ilen_next;
    end
  end

endmodule

[src/sbt_queue.sv]
// ---------------------------------------------------------------------------
// sbt_queue: token queue between lexer and result port
// Writes zero, one or two tokens per cycle, reads one per cycle while rd is high.
// ---------------------------------------------------------------------------
module sbt_queue import sbt_pkg::*; #(
  parameter int OFFSET_WIDTH = OffsetWidthDefault,
  parameter int LINE_WIDTH   = LineWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [1:0]              wr_count,
  input  logic [KindWidth-1:0]    kind0,
  input  logic [KindWidth-1:0]    kind1,
  input  logic [LINE_WIDTH-1:0]   line0,
  input  logic [LINE_WIDTH-1:0]   line1,
  input  logic [LINE_WIDTH-1:0]   col0,
  input  logic [LINE_WIDTH-1:0]   col1,
  input  logic [OFFSET_WIDTH-1:0] soff0,
  input  logic [OFFSET_WIDTH-1:0] soff1,
  input  logic [OFFSET_WIDTH-1:0] eoff0,
  input  logic [OFFSET_WIDTH-1:0] eoff1,
  input  logic                    rd,
  output logic                    has_room,
  output logic                    not_empty,
  output logic [KindWidth-1:0]    token_kind,
  output logic [LINE_WIDTH-1:0]   start_line,
  output logic [LINE_WIDTH-1:0]   start_column,
  output logic [OFFSET_WIDTH-1:0] start_offset,
  output logic [OFFSET_WIDTH-1:0] end_offset,
  output logic                    last_of_run
);

  localparam int Depth = 4;
  localparam int EntW  = KindWidth + 2 * LINE_WIDTH + 2 * OFFSET_WIDTH + 1;

  logic [EntW-1:0] ent [Depth];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic [EntW-1:0] e0, e1;

  assign e0 = {kind0, line0, col0, soff0, eoff0, wr_count == 2'd1};
  assign e1 = {kind1, line1, col1, soff1, eoff1, 1'b1};
  // room for two more tokens; a pop in the same cycle is not counted
  assign has_room  = cnt <= 3'd2;
  assign not_empty = cnt != 3'd0;
  assign {token_kind, start_line, start_column, start_offset, end_offset, last_of_run} =
    ent[rp];

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) ent[wp] <= e0;
    if (wr_count == 2'd2) ent[wp + 2'd1] <= e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp  <= wp + wr_count;
      rp  <= rp + {1'b0, rd};
      cnt <= cnt + {1'b0, wr_count} - {2'b0, rd};
    end
  end

endmodule

[src/source_byte_tokenizer.sv]
// ---------------------------------------------------------------------------
// source_byte_tokenizer: streaming lexer for source text
// Lexer front end feeding a four-entry token queue that drives the results.
// ---------------------------------------------------------------------------
//  channel | signals                         | transfer when
//  bytes   | push, full, char_byte           | push && !full
//  tokens  | pop, empty, token_kind ... last | pop && !empty
//
// One byte per cycle while full is low, giving zero to two tokens; the lexer
// state is registered. full rises when fewer than two queue slots are free.
// Synchronous reset returns lexer state to line 1, column 0, offset 0 and
// empties the queue. Tokens leave one per cycle while pop is high.
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int OFFSET_WIDTH = OffsetWidthDefault,
  parameter int LINE_WIDTH   = LineWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              char_byte,
  input  logic                    pop,
  output logic                    empty,
  output logic [4:0]              token_kind,
  output logic [LINE_WIDTH-1:0]   start_line,
  output logic [LINE_WIDTH-1:0]   start_column,
  output logic [OFFSET_WIDTH-1:0] start_offset,
  output logic [OFFSET_WIDTH-1:0] end_offset,
  output logic                    last_of_run
);

  logic take, room, ne;
  logic [1:0] cnt;
  logic [KindWidth-1:0] k0, k1;
  logic [LINE_WIDTH-1:0] l0, l1, c0, c1;
  logic [OFFSET_WIDTH-1:0] s0, s1, e0, e1;

  assign full  = !room;
  assign empty = !ne;
  assign take  = push && room;

  sbt_front #(.OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk, .rst, .take, .char_byte, .tok_count(cnt),
    .kind0(k0), .kind1(k1), .line0(l0), .line1(l1), .col0(c0), .col1(c1),
    .soff0(s0), .soff1(s1), .eoff0(e0), .eoff1(e1)
  );

  sbt_queue #(.OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_queue (
    .clk, .rst, .wr_count(take ? cnt : 2'd0),
    .kind0(k0), .kind1(k1), .line0(l0), .line1(l1), .col0(c0), .col1(c1),
    .soff0(s0), .soff1(s1), .eoff0(e0), .eoff1(e1),
    .rd(pop && ne), .has_room(room), .not_empty(ne),
    .token_kind, .start_line, .start_column, .start_offset, .end_offset, .last_of_run
  );

endmodule

[src/sbt_checker.sv]
// ---------------------------------------------------------------------------
// sbt_checker: port-level checks for the tokenizer
// Bound to the top level.
// ---------------------------------------------------------------------------
module sbt_checker import sbt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [4:0] token_kind,
  input logic       last_of_run
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("not empty after reset");

  // reset leaves room for a byte
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // EOF always closes a run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind == K_EOF) |-> last_of_run)
    else $error("EOF not last of run");

  // stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(token_kind)))
    else $error("token changed while stalled");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
  .clk, .rst, .full, .empty, .pop, .token_kind, .last_of_run
);

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb: self-checking bench for source_byte_tokenizer
// Streams source bytes through the push/full side and predicts every token,
// with its positions, in a scoreboard. Tokens popped from the result side
// are compared field by field. Random gaps and stalls run in several phases.
// ---------------------------------------------------------------------------
module tb;
  import sbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = 16;
  localparam int OW = 24;
  localparam int RANDOM_BYTES = 1400;
  localparam int CYCLE_LIMIT = 3000000;

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ = 8'h3D;

  // punctuation and operator kinds
  localparam logic [4:0] K_LPAREN = 5'd8, K_RPAREN = 5'd9, K_LBRACE = 5'd10;
  localparam logic [4:0] K_RBRACE = 5'd11, K_LBRACK = 5'd12, K_RBRACK = 5'd13;
  localparam logic [4:0] K_COMMA = 5'd14, K_DOT = 5'd15, K_SEMI = 5'd20;
  localparam logic [4:0] K_MINUS = 5'd16, K_PLUS = 5'd18, K_STAR = 5'd21;
  localparam logic [4:0] K_BANG = 5'd23, K_ASSIGN = 5'd25, K_LT = 5'd27;
  localparam logic [4:0] K_GT = 5'd29, K_NOOP = 5'd0;

  typedef struct packed {
    logic [4:0]    kind;
    logic [LW-1:0] sline;
    logic [LW-1:0] scol;
    logic [OW-1:0] soff;
    logic [OW-1:0] eoff;
    logic          last;
  } token_t;

  // lexer predictor plus queue of tokens still to be popped
  class token_scoreboard;
    token_t pending_tokens[$];
    logic [2:0] mode;
    logic [7:0] op_byte;
    logic [LW-1:0] tok_line, tok_col, line_no, col_no;
    logic [OW-1:0] tok_off, off_no;
    logic [31:0] id_bytes;
    logic [2:0] id_len;
    token_t run[$];

    function new();
      restart();
    endfunction

    function void restart();
      mode = M_IDLE;
      op_byte = 8'h00;
      tok_line = 1;
      tok_col = 0;
      tok_off = 0;
      line_no = 1;
      col_no = 0;
      off_no = 0;
      id_bytes = 0;
      id_len = 0;
    endfunction

    function void step_pos(logic [7:0] b, bit lf_only);
      if (off_no != '1) off_no++;
      if (b == CH_LF || (!lf_only && b == CH_CR)) begin
        if (line_no != '1) line_no++;
        col_no = 0;
      end else if (col_no != '1) begin
        col_no++;
      end
    endfunction

    function void mark();
      tok_line = line_no;
      tok_col = col_no;
      tok_off = off_no;
    endfunction

    function void emit(logic [4:0] k);
      token_t t;
      t.kind = k;
      t.sline = tok_line;
      t.scol = tok_col;
      t.soff = tok_off;
      t.eoff = off_no;
      t.last = 1'b0;
      run.push_back(t);
    endfunction

    function bit letter(logic [7:0] b);
      logic [7:0] l;
      l = b | 8'h20;
      return (l >= "a" && l <= "z") || b == "_";
    endfunction

    function logic [4:0] word_kind();
      if (id_len == 2 && id_bytes == "if") return K_IF;
      if (id_len == 3 && id_bytes == "ret") return K_RET;
      if (id_len == 4 && id_bytes == "else") return K_ELSE;
      if (id_len == 4 && id_bytes == "func") return K_FUNC;
      return K_IDENT;
    endfunction

    function logic [4:0] punct(logic [7:0] b);
      case (b)
        "(": return K_LPAREN;
        ")": return K_RPAREN;
        "{": return K_LBRACE;
        "}": return K_RBRACE;
        "[": return K_LBRACK;
        "]": return K_RBRACK;
        ",": return K_COMMA;
        ".": return K_DOT;
        ";": return K_SEMI;
        default: return K_NOOP;
      endcase
    endfunction

    // lone operator; the doubled form is one higher
    function logic [4:0] oper(logic [7:0] b);
      case (b)
        "-": return K_MINUS;
        "+": return K_PLUS;
        "*": return K_STAR;
        "!": return K_BANG;
        "=": return K_ASSIGN;
        "<": return K_LT;
        ">": return K_GT;
        default: return K_NOOP;
      endcase
    endfunction

    function logic [7:0] follow(logic [7:0] b);
      if (b == CH_MINUS || b == CH_PLUS || b == CH_STAR) return b;
      return CH_EQ;
    endfunction

    function void from_idle(logic [7:0] b);
      if (b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR) begin
        step_pos(b, 0);
        return;
      end
      mark();
      step_pos(b, 0);
      if (letter(b)) begin
        mode = M_IDENT;
        id_bytes = {24'h0, b};
        id_len = 1;
      end else if (punct(b) != K_NOOP) begin
        emit(punct(b));
      end else if (oper(b) != K_NOOP) begin
        mode = M_OP;
        op_byte = b;
      end else if (b == CH_SLASH) begin
        mode = M_SLASH;
      end else if (b == CH_QUOTE) begin
        mode = M_STRING;
      end else begin
        emit(K_ERROR);
      end
    endfunction

    // one accepted source byte
    function void note_byte(logic [7:0] b);
      bit held;
      held = 0;
      run.delete();
      case (mode)
        M_IDENT: begin
          if (letter(b) || (b >= "0" && b <= "9")) begin
            if (id_len < 4) id_bytes = {id_bytes[23:0], b};
            if (id_len < 7) id_len++;
            step_pos(b, 0);
            held = 1;
          end else begin
            emit(word_kind());
            mode = M_IDLE;
          end
        end
        M_OP: begin
          if (b == follow(op_byte)) begin
            step_pos(b, 0);
            emit(oper(op_byte) + 5'd1);
            held = 1;
          end else begin
            emit(oper(op_byte));
          end
          mode = M_IDLE;
        end
        M_SLASH: begin
          if (b == CH_SLASH || b == CH_STAR) begin
            step_pos(b, 0);
            mode = (b == CH_SLASH) ? M_LINE : M_BLOCK;
            held = 1;
          end else begin
            emit(K_SLASH);
            mode = M_IDLE;
          end
        end
        M_LINE: begin
          if (b == CH_LF || b == CH_NUL) begin
            mode = M_IDLE;
          end else begin
            step_pos(b, 1);
            held = 1;
          end
        end
        M_BLOCK, M_STAR, M_STRING: begin
          if (b == CH_NUL) begin
            emit(K_ERROR);
            mode = M_IDLE;
          end else begin
            step_pos(b, 1);
            held = 1;
            if (mode == M_STRING) begin
              if (b == CH_QUOTE) begin
                emit(K_STRING);
                mode = M_IDLE;
              end
            end else if (mode == M_STAR && b == CH_SLASH) begin
              mode = M_IDLE;
            end else begin
              mode = (b == CH_STAR) ? M_STAR : M_BLOCK;
            end
          end
        end
        default: mode = M_IDLE;
      endcase
      if (!held) begin
        if (b == CH_NUL) begin
          mark();
          emit(K_EOF);
          restart();
        end else begin
          from_idle(b);
        end
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_tokens.push_back(run[i]);
    endfunction

    // empty string when the token matches the oldest expectation
    function string check_token(token_t got);
      token_t e;
      if (pending_tokens.size() == 0)
        return $sformatf("unexpected token kind %0d", got.kind);
      e = pending_tokens.pop_front();
      if (got !== e)
        return $sformatf("token got k%0d l%0d c%0d s%0d e%0d t%0b exp k%0d l%0d c%0d s%0d e%0d t%0b",
          got.kind, got.sline, got.scol, got.soff, got.eoff, got.last,
          e.kind, e.sline, e.scol, e.soff, e.eoff, e.last);
      return "";
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic [7:0] char_byte = 0;
  logic pop = 0;
  logic full, empty, last_of_run;
  logic [4:0] token_kind;
  logic [LW-1:0] start_line, start_column;
  logic [OW-1:0] start_offset, end_offset;

  token_scoreboard sb = new();
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  source_byte_tokenizer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .pop(pop), .empty(empty), .token_kind(token_kind), .start_line(start_line),
    .start_column(start_column), .start_offset(start_offset),
    .end_offset(end_offset), .last_of_run(last_of_run)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  task automatic report(string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  // timeout watch
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: check each transfer, then decide on a stall
  always @(posedge clk) begin
    string msg;
    if (!rst && pop && !empty) begin
      msg = sb.check_token({token_kind, start_line, start_column, start_offset,
                            end_offset, last_of_run});
      if (msg != "") report(msg);
    end
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // one byte transfer, with random gaps ahead of it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    char_byte <= b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_tokens.size() != 0) @(posedge clk);
  endtask

  // one random fragment of source text, mostly well formed
  task automatic send_fragment();
    string words[8] = '{"if", "ret", "else", "func", "x", "if_", "Func9", "returnval"};
    string ops[12] = '{"--", "++", "**", "!=", "==", "<=", ">=", "-", "+", "!", "=", "<"};
    int n;
    case ($urandom_range(0, 13))
      0, 1: send_text(words[$urandom_range(0, 7)]);
      2: begin
        n = $urandom_range(1, 9);
        repeat (n) send_byte($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                                  : 8'("0" + $urandom_range(0, 9)));
      end
      3, 4: send_text(ops[$urandom_range(0, 11)]);
      5: send_byte(8'("(" + $urandom_range(0, 1)));
      6: send_text($urandom_range(0, 1) ? "{};" : "[],.");
      7: begin
        send_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) send_byte($urandom_range(0, 1) ? CH_LF : 8'("a" + $urandom_range(0, 25)));
        if ($urandom_range(0, 7) != 0) send_byte(CH_QUOTE);
      end
      8: begin
        send_text($urandom_range(0, 1) ? "/*" : "//");
        n = $urandom_range(0, 5);
        repeat (n) send_byte($urandom_range(0, 2) == 0 ? CH_STAR : 8'($urandom_range(1, 255)));
        send_text($urandom_range(0, 1) ? "*/" : "\n");
      end
      9, 10: send_byte($urandom_range(0, 1) ? CH_SP : ($urandom_range(0, 1) ? CH_LF : CH_CR));
      11: send_byte(CH_TAB);
      12: send_byte(8'($urandom_range(1, 255)));
      default: send_byte($urandom_range(0, 3) == 0 ? CH_NUL : CH_SLASH);
    endcase
  endtask

  initial begin
    int phase;
    int sent;
    int base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: keywords, every operator, comments, strings, errors
    send_text("if ret else func iff x_9 Zq()\t{}[],.;\r- -- + ++ * ** ! != = == < <= > >=");
    send_text(" / //c\n/* a * */ /**/ \"s\nt\" 7 @ \"open");
    send_byte(CH_NUL);
    send_text("/* never closed");
    send_byte(CH_NUL);
    send_text("ab// tail");
    send_byte(CH_NUL);
    send_text("-");
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_text("b+");
    send_byte(CH_NUL);
    drain();

    // random text over four idling phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 78; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 78; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      sent = 0;
      base = bytes_sent;
      while (bytes_sent - base < RANDOM_BYTES / 4) begin
        send_fragment();
        sent++;
        if (sent == 40) drain();
      end
    end
    send_byte(CH_NUL);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && sb.pending_tokens.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
